// ===== hw/rtl/i2c_target_register_map_defines.svh =====
// Assertion macros used by the checker file of the I2C target register map.
// Each macro expects signals named aclk and aresetn in the calling scope.
`ifndef I2C_TARGET_REGISTER_MAP_DEFINES_SVH
`define I2C_TARGET_REGISTER_MAP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define I2CTRM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define I2CTRM_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/i2ctrm_pkg.sv =====
`timescale 1ns / 1ps

package i2ctrm_pkg;

    // Bus event codes
    typedef enum logic [1:0] {
        KIND_ADDR = 2'd0,
        KIND_RX   = 2'd1,
        KIND_TX   = 2'd2,
        KIND_STOP = 2'd3
    } kind_t;

    // Register selection codes
    typedef enum logic [1:0] {
        SEL_NONE = 2'd0,
        SEL_R03  = 2'd1,
        SEL_R04  = 2'd2,
        SEL_R05  = 2'd3
    } sel_t;

    localparam int          NumBytes  = 15;
    localparam int          AddrW     = 4;
    localparam logic [3:0]  IdxMax    = 4'd15;
    localparam logic [7:0]  IdReg03   = 8'h03;
    localparam logic [7:0]  IdReg04   = 8'h04;
    localparam logic [7:0]  IdReg05   = 8'h05;
    localparam logic [7:0]  TxIdle    = 8'hFF;

    // Write request from the event decoder to the byte store
    typedef struct packed {
        logic             en;
        logic [AddrW-1:0] addr;
        logic [7:0]       data;
    } wr_req_t;

    // Power-on contents of the byte store
    function automatic logic [7:0] reg_init(input logic [AddrW-1:0] a);
        logic [7:0] v;
        unique case (a)
            4'd0:    v = 8'h12;
            4'd1:    v = 8'h34;
            4'd2:    v = 8'h56;
            4'd3:    v = 8'h78;
            4'd4:    v = 8'h01;
            4'd5:    v = 8'h00;
            4'd6:    v = 8'hFF;
            4'd7:    v = 8'hAA;
            4'd8:    v = 8'hAA;
            4'd9:    v = 8'hAA;
            4'd10:   v = 8'hAA;
            4'd11:   v = 8'hAB;
            4'd12:   v = 8'hAA;
            4'd13:   v = 8'hAA;
            4'd14:   v = 8'hCC;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    function automatic logic [AddrW-1:0] reg_base(input sel_t s);
        logic [AddrW-1:0] b;
        unique case (s)
            SEL_R04: b = 4'd4;
            SEL_R05: b = 4'd12;
            default: b = 4'd0;
        endcase
        return b;
    endfunction

    function automatic logic [3:0] reg_len(input sel_t s);
        logic [3:0] l;
        unique case (s)
            SEL_R03: l = 4'd4;
            SEL_R04: l = 4'd8;
            SEL_R05: l = 4'd3;
            default: l = 4'd0;
        endcase
        return l;
    endfunction

    function automatic sel_t decode_id(input logic [7:0] id);
        sel_t s;
        priority if (id == IdReg03) s = SEL_R03;
        else if (id == IdReg04)     s = SEL_R04;
        else if (id == IdReg05)     s = SEL_R05;
        else                        s = SEL_NONE;
        return s;
    endfunction

endpackage

// ===== hw/rtl/i2c_target_register_map.sv =====
`timescale 1ns / 1ps

// I2C target register map: byte-level back end for three multi-byte registers.
// Input channel (s_*): one bus event per transaction - address match, byte
// received, byte to send, or stop. Output channel (m_*): exactly one result
// per event with the byte to send, a stored flag and the current selection.
// The first received byte after a counter clear selects register 0x03, 0x04
// or 0x05; later bytes write that register in order within its length.
// The result is registered: it is valid the cycle after the event is accepted.
// Throughput: one event per cycle unless the receiver stalls; the single output
// register is refilled in the same cycle that its result is taken.
// When the receiver stalls, the result holds and s_ready drops until m_ready
// returns.
// Reset (aresetn low, synchronous): byte counter and selection clear, the byte
// store reloads its power-on values, and the output register empties.

module i2c_target_register_map (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_kind,
    input  logic        s_master_reading,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_tx_byte,
    output logic        m_stored,
    output logic [1:0]  m_selected
);
    import i2ctrm_pkg::*;

    logic [3:0]       idx_reg, idx_next;
    sel_t             sel_reg, sel_next;
    logic             m_valid_reg;
    logic [7:0]       tx_reg, tx_next;
    logic             stored_reg, stored_next;
    sel_t             selected_reg;
    wr_req_t          wr;
    logic [AddrW-1:0] rd_addr;
    logic [7:0]       rd_data;
    logic [3:0]       off;
    logic [3:0]       idx_bump;
    logic             in_range;
    logic             accept;
    kind_t            kind;

    assign kind    = kind_t'(s_kind);
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    // Offset within the selected register: received data starts after the ID
    assign off      = (kind == KIND_RX) ? (idx_reg - 4'd1) : idx_reg;
    assign in_range = (sel_reg != SEL_NONE) && (off < reg_len(sel_reg));
    assign rd_addr  = reg_base(sel_reg) + off;
    assign idx_bump = (idx_reg < IdxMax) ? (idx_reg + 4'd1) : idx_reg;

    i2ctrm_regfile u_regfile (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (wr),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Event decode
    always_comb begin
        idx_next    = idx_reg;
        sel_next    = sel_reg;
        tx_next     = 8'h00;
        stored_next = 1'b0;
        wr.en       = 1'b0;
        wr.addr     = rd_addr;
        wr.data     = s_rx_byte;
        unique case (kind)
            KIND_ADDR: begin
                if (s_master_reading) idx_next = 4'd0;
            end
            KIND_RX: begin
                if (idx_reg == 4'd0) begin
                    sel_next = decode_id(s_rx_byte);
                end else if (in_range) begin
                    wr.en       = accept;
                    stored_next = 1'b1;
                end
                idx_next = idx_bump;
            end
            KIND_TX: begin
                tx_next  = in_range ? rd_data : TxIdle;
                idx_next = idx_bump;
            end
            KIND_STOP: begin
                idx_next = 4'd0;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg     <= 4'd0;
            sel_reg     <= SEL_NONE;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                idx_reg <= idx_next;
                sel_reg <= sel_next;
            end
            if (accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (accept) begin
            tx_reg       <= tx_next;
            stored_reg   <= stored_next;
            selected_reg <= sel_next;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_tx_byte  = tx_reg;
    assign m_stored   = stored_reg;
    assign m_selected = selected_reg;

endmodule

// ===== hw/rtl/i2ctrm_regfile.sv =====
`timescale 1ns / 1ps

module i2ctrm_regfile (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  i2ctrm_pkg::wr_req_t           wr,
    input  logic [i2ctrm_pkg::AddrW-1:0]  rd_addr,
    output logic [7:0]                    rd_data
);
    import i2ctrm_pkg::*;

    logic [7:0] bytes_reg [NumBytes];

    // Byte store: reset loads the power-on values, one write port
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NumBytes; i++) begin
                bytes_reg[i] <= reg_init(AddrW'(i));
            end
        end else if (wr.en) begin
            bytes_reg[wr.addr] <= wr.data;
        end
    end

    // Asynchronous read; unused code reads as zero
    assign rd_data = (rd_addr < AddrW'(NumBytes)) ? bytes_reg[rd_addr] : 8'h00;

endmodule

// ===== hw/rtl/i2ctrm_checker.sv =====
`timescale 1ns / 1ps
`include "i2c_target_register_map_defines.svh"

module i2ctrm_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_tx_byte,
    input logic       m_stored,
    input logic [1:0] m_selected
);
    import i2ctrm_pkg::*;

    logic        accept;
    logic        stall;
    logic        stored_ok;
    logic [10:0] result_bus;

    assign accept     = s_valid && s_ready;
    assign stall      = m_valid && !m_ready;
    assign stored_ok  = (m_selected != SEL_NONE) && (m_tx_byte == 8'h00);
    assign result_bus = {m_tx_byte, m_stored, m_selected};

    // Input is only back-pressured by a pending, untaken result
    `I2CTRM_ASSERT_IMP(a_ready_only_when_full, !s_ready, stall, "s_ready low without stall")

    // Every accepted event yields a result the next cycle
    `I2CTRM_ASSERT_NXT(a_result_follows, accept, m_valid, "result missing after accept")

    // A stored byte needs a selected register and sends nothing
    `I2CTRM_ASSERT_IMP(a_stored_sel, m_valid && m_stored, stored_ok, "stored without selection")

    // Stalled result holds
    `I2CTRM_ASSERT_NXT(a_stall_hold, stall, m_valid && $stable(result_bus), "result moved in stall")

endmodule

bind i2c_target_register_map i2ctrm_checker u_i2ctrm_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .s_valid    (s_valid),
    .s_ready    (s_ready),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_tx_byte  (m_tx_byte),
    .m_stored   (m_stored),
    .m_selected (m_selected)
);

// ===== dv/i2c_target_register_map_test.sv =====
`timescale 1ns / 1ps

module i2c_target_register_map_test;
    import i2ctrm_pkg::*;

    localparam int unsigned RandomEvents = 1200;
    localparam int unsigned IdleLimit    = 2000;

    // One bus event as the sender queues it
    typedef struct {
        kind_t      kind;
        logic       rd;
        logic [7:0] rx;
    } bus_event_t;

    // One result of the block
    typedef struct {
        logic [7:0] tx;
        logic       stored;
        sel_t       sel;
    } map_result_t;

    // Register map predictor and store of expected results
    class reg_map_scoreboard;
        logic [3:0]  byte_idx;
        sel_t        sel_reg;
        logic [7:0]  mem [NumBytes];
        map_result_t pending [$];
        int unsigned mismatches;
        int unsigned checked;
        int unsigned stored_count;
        int unsigned ff_count;
        int unsigned sat_hits;

        function new();
            byte_idx = '0;
            sel_reg  = SEL_NONE;
            mem = '{8'h12, 8'h34, 8'h56, 8'h78,
                    8'h01, 8'h00, 8'hFF, 8'hAA, 8'hAA, 8'hAA, 8'hAA, 8'hAB,
                    8'hAA, 8'hAA, 8'hCC};
            mismatches   = 0;
            checked      = 0;
            stored_count = 0;
            ff_count     = 0;
            sat_hits     = 0;
        endfunction

        // Advance the predicted state by one accepted event
        function void note_event(kind_t kind, logic rd, logic [7:0] rx);
            map_result_t r;
            logic [3:0]  base;
            logic [3:0]  len;
            logic [3:0]  off;
            r.tx     = 8'h00;
            r.stored = 1'b0;
            // window of the register selected before this event
            case (sel_reg)
                SEL_R03: begin base = 4'd0;  len = 4'd4; end
                SEL_R04: begin base = 4'd4;  len = 4'd8; end
                SEL_R05: begin base = 4'd12; len = 4'd3; end
                default: begin base = 4'd0;  len = 4'd0; end
            endcase
            case (kind)
                KIND_ADDR: begin
                    if (rd) byte_idx = '0;
                end
                KIND_RX: begin
                    if (byte_idx == 4'd0) begin
                        case (rx)
                            IdReg03: sel_reg = SEL_R03;
                            IdReg04: sel_reg = SEL_R04;
                            IdReg05: sel_reg = SEL_R05;
                            default: sel_reg = SEL_NONE;
                        endcase
                    end else begin
                        off = byte_idx - 4'd1;
                        if (sel_reg != SEL_NONE && off < len) begin
                            mem[base + off] = rx;
                            r.stored = 1'b1;
                            stored_count++;
                        end
                    end
                    if (byte_idx != IdxMax) byte_idx++;
                    else sat_hits++;
                end
                KIND_TX: begin
                    r.tx = TxIdle;
                    if (sel_reg != SEL_NONE && byte_idx < len) r.tx = mem[base + byte_idx];
                    if (r.tx == TxIdle) ff_count++;
                    if (byte_idx != IdxMax) byte_idx++;
                    else sat_hits++;
                end
                default: begin
                    byte_idx = '0;
                end
            endcase
            r.sel = sel_reg;
            pending.push_back(r);
        endfunction

        // Compare one accepted result with the oldest expectation
        function void check_result(logic [7:0] tx, logic stored, logic [1:0] sel);
            map_result_t e;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("error: result with nothing expected: tx=%02h stored=%0d sel=%0d",
                             tx, stored, sel);
                return;
            end
            e = pending.pop_front();
            checked++;
            if (tx !== e.tx || stored !== e.stored || sel !== e.sel) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("error: result %0d: exp tx=%02h st=%0d sel=%0d, got %02h %0d %0d",
                             checked, e.tx, e.stored, e.sel, tx, stored, sel);
            end
        endfunction
    endclass

    logic       aclk             = 1'b0;
    logic       aresetn          = 1'b0;
    logic       s_valid          = 1'b0;
    logic       s_ready;
    logic [1:0] s_kind           = KIND_STOP;
    logic       s_master_reading = 1'b0;
    logic [7:0] s_rx_byte        = 8'h00;
    logic       m_valid;
    logic       m_ready          = 1'b0;
    logic [7:0] m_tx_byte;
    logic       m_stored;
    logic [1:0] m_selected;

    reg_map_scoreboard sb;
    bus_event_t        bus_events [$];
    int unsigned       idle_cycles = 0;
    int unsigned       rx_mode     = 0;
    int unsigned       mode_left   = 0;
    logic [1:0]        rx_phase    = 2'd0;

    i2c_target_register_map i_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_kind           (s_kind),
        .s_master_reading (s_master_reading),
        .s_rx_byte        (s_rx_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_tx_byte        (m_tx_byte),
        .m_stored         (m_stored),
        .m_selected       (m_selected)
    );

    always #2 aclk = ~aclk;

    function automatic void push_event(kind_t kind, logic rd, logic [7:0] rx);
        bus_event_t ev;
        ev.kind = kind;
        ev.rd   = rd;
        ev.rx   = rx;
        bus_events.push_back(ev);
    endfunction

    // Mostly valid register IDs, sometimes any byte
    function automatic logic [7:0] pick_id();
        logic [7:0] id;
        case ($urandom_range(0, 4))
            0: id = IdReg03;
            1: id = IdReg04;
            2: id = IdReg05;
            3: id = 8'($urandom_range(0, 255));
            default: id = IdReg03 + 8'($urandom_range(0, 2));
        endcase
        return id;
    endfunction

    // Transfer length, occasionally long enough to saturate the counter
    function automatic int unsigned pick_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(12, 20) : $urandom_range(0, 9);
    endfunction

    task automatic build_stimulus();
        int unsigned n;
        // directed: reads with nothing selected, writes into 0x05 past its end,
        // read back past the end, unknown ID, then read 0x03 power-on values
        push_event(KIND_TX,   1'b0, 8'h00);
        push_event(KIND_STOP, 1'b1, 8'hFF);
        push_event(KIND_ADDR, 1'b0, 8'hFF);
        push_event(KIND_RX,   1'b1, IdReg05);
        push_event(KIND_RX,   1'b0, 8'hFF);
        push_event(KIND_RX,   1'b0, 8'h00);
        push_event(KIND_RX,   1'b0, 8'hA5);
        push_event(KIND_RX,   1'b0, 8'h5A);
        push_event(KIND_ADDR, 1'b1, 8'h00);
        repeat (4) push_event(KIND_TX, 1'b0, 8'hFF);
        push_event(KIND_STOP, 1'b0, 8'h00);
        push_event(KIND_RX,   1'b0, 8'h77);
        push_event(KIND_RX,   1'b1, 8'h12);
        push_event(KIND_TX,   1'b1, 8'h00);
        push_event(KIND_STOP, 1'b0, 8'hFF);
        push_event(KIND_RX,   1'b0, IdReg03);
        push_event(KIND_ADDR, 1'b1, 8'hFF);
        repeat (5) push_event(KIND_TX, 1'b0, 8'h00);

        // random: well-formed writes and reads with random content, plus noise
        while (bus_events.size() < RandomEvents + 25) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    push_event(KIND_STOP, 1'($urandom), 8'($urandom));
                    push_event(KIND_ADDR, 1'b0, 8'($urandom));
                    push_event(KIND_RX, 1'($urandom), pick_id());
                    n = pick_len();
                    repeat (n) push_event(KIND_RX, 1'($urandom), 8'($urandom));
                    if ($urandom_range(0, 4) != 0) push_event(KIND_STOP, 1'($urandom), 8'($urandom));
                end
                4, 5, 6, 7: begin
                    push_event(KIND_ADDR, 1'b0, 8'($urandom));
                    push_event(KIND_RX, 1'($urandom), pick_id());
                    push_event(KIND_ADDR, 1'b1, 8'($urandom));
                    n = pick_len();
                    repeat (n) push_event(KIND_TX, 1'($urandom), 8'($urandom));
                    if ($urandom_range(0, 4) != 0) push_event(KIND_STOP, 1'($urandom), 8'($urandom));
                end
                default: begin
                    n = $urandom_range(1, 6);
                    repeat (n)
                        push_event(kind_t'($urandom_range(0, 3)), 1'($urandom), 8'($urandom));
                end
            endcase
        end
    endtask

    // Send all queued events in bursts with random gaps
    task automatic drive_events();
        int unsigned burst_left;
        int unsigned gap;
        burst_left = $urandom_range(1, 40);
        foreach (bus_events[i]) begin
            if (burst_left == 0) begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                if (gap > 0) begin
                    s_valid <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
                burst_left = $urandom_range(1, 40);
            end
            s_valid          <= 1'b1;
            s_kind           <= bus_events[i].kind;
            s_master_reading <= bus_events[i].rd;
            s_rx_byte        <= bus_events[i].rx;
            @(posedge aclk);
            while (!s_ready) @(posedge aclk);
            sb.note_event(bus_events[i].kind, bus_events[i].rd, bus_events[i].rx);
            burst_left--;
        end
        s_valid <= 1'b0;
    endtask

    // Result monitor and receiver stall pattern
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_result(m_tx_byte, m_stored, m_selected);
        rx_phase <= rx_phase + 2'd1;
        if (mode_left == 0) begin
            rx_mode   <= $urandom_range(0, 3);
            mode_left <= $urandom_range(50, 300);
        end else begin
            mode_left <= mode_left - 1;
        end
        case (rx_mode)
            0:       m_ready <= 1'b1;
            1:       m_ready <= 1'($urandom_range(0, 1));
            2:       m_ready <= (rx_phase == 2'd3);
            default: m_ready <= ($urandom_range(0, 9) != 0);
        endcase
    end

    // Watchdog on cycles without any transaction
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IdleLimit) begin
                $display("watchdog: no transaction for %0d cycles", IdleLimit);
                $display("FAIL");
                $finish;
            end
        end
    end

    // Main sequence
    initial begin
        int unsigned failures;
        sb = new();
        build_stimulus();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        drive_events();
        while (sb.pending.size() > 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        failures = sb.mismatches + sb.pending.size();
        $display("Sent %0d bus events, checked %0d results with %0d mismatches",
                 bus_events.size(), sb.checked, sb.mismatches);
        $display("Bytes stored %0d, reads returning 0xFF %0d, saturated counter steps %0d",
                 sb.stored_count, sb.ff_count, sb.sat_hits);
        if (failures == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/i2ctrm_pkg.sv
hw/rtl/i2ctrm_regfile.sv
hw/rtl/i2c_target_register_map.sv
hw/rtl/i2ctrm_checker.sv
dv/i2c_target_register_map_test.sv
